@@ hw/rtl/svpc_pkg.sv @@
package svpc_pkg;

  localparam int VOLT_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int PER_W      = 16;
  localparam int CMP_W      = 15;
  localparam int TERM_W     = 42;
  localparam int MAG_W      = 41;
  localparam int SUM_W      = 42;
  localparam int PROD_W     = MAG_W + PER_W;
  localparam int QUO_W      = 32;
  localparam int REM_W      = SUM_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int FULL_W     = PER_W + FRAC_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PWM_PERIOD = 1'b0;

  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(8400);

  localparam logic signed [TERM_W-1:0] K_SQRT3        = TERM_W'(113512);
  localparam logic signed [TERM_W-1:0] K_HALF_SQRT3   = TERM_W'(56756);
  localparam logic signed [TERM_W-1:0] K_THREE_HALVES = TERM_W'(98304);

  typedef enum logic [2:0] {
    SEC_ZERO = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6
  } sector_t;

  typedef struct packed {
    sector_t sector;
    logic    ovm;
    logic    fault;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic             vld;
    div_lane_t        x;
    div_lane_t        y;
    logic [SUM_W-1:0] dvs;
    tag_t             tag;
  } div_stage_t;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic div_lane_t lane_step(div_lane_t l, logic [SUM_W-1:0] d);
    logic [REM_W:0] trial;
    logic           fits;
    div_lane_t      r;
    trial = {l.rem, l.num[QUO_W-1]};
    fits  = trial >= {1'b0, d};
    r.rem = fits ? REM_W'(trial - {1'b0, d}) : REM_W'(trial);
    r.num = {l.num[QUO_W-2:0], 1'b0};
    r.quo = {l.quo[QUO_W-2:0], fits};
    return r;
  endfunction

  function automatic div_stage_t stage_step(div_stage_t s);
    div_stage_t r;
    r   = s;
    r.x = lane_step(s.x, s.dvs);
    r.y = lane_step(s.y, s.dvs);
    return r;
  endfunction

endpackage

@@ hw/rtl/svpc_if.sv @@
interface svpc_in_if import svpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] alpha_voltage;
  logic signed [VOLT_W-1:0] beta_voltage;
  logic        [VOLT_W-1:0] bus_voltage;

  modport source (output valid, alpha_voltage, beta_voltage, bus_voltage, input ready);
  modport sink   (input valid, alpha_voltage, beta_voltage, bus_voltage, output ready);
endinterface

interface svpc_out_if import svpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMP_W-1:0] compare_a;
  logic [CMP_W-1:0] compare_b;
  logic [CMP_W-1:0] compare_c;
  logic             overmodulated;
  logic             bus_fault;

  modport source (output valid, compare_a, compare_b, compare_c, overmodulated, bus_fault,
                  input ready);
  modport sink   (input valid, compare_a, compare_b, compare_c, overmodulated, bus_fault,
                  output ready);
endinterface

@@ hw/rtl/space_vector_pwm_compare_top.sv @@
// Seven-segment space-vector PWM compare generator. Each transaction on in_ch
// carries one alpha/beta voltage demand and the measured bus voltage (units of
// 2^-10 V); each transaction on out_ch carries the three phase timer compares,
// an overmodulation flag and a bus fault flag. One transaction is accepted per
// clock unless a finished result is held on out_ch; each input passes through 4 front stages
// (constant products, sector decode, active-vector magnitudes, period scaling),
// 32 stages of a two-lane restoring divider that yields one quotient bit per
// stage, and 3 stages that clamp, form the quarter and half times and route
// them by sector. The whole pipeline holds while a finished result waits on
// out_ch, so nothing is dropped or repeated. pwm_period sits at APB byte
// address 0 (reset 8400) and is to be written only while the pipeline is empty.
module space_vector_pwm_compare_top import svpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  svpc_in_if.sink               in_ch,
  svpc_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic             adv;
  logic [PER_W-1:0] pwm_period;
  div_stage_t       entry;
  div_stage_t       quo;

  // Advance every stage when the output register is empty or being drained.
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  svpc_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pwm_period (pwm_period)
  );

  // Sector decode and numerator/divisor setup.
  svpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_ch.valid),
    .alpha      (in_ch.alpha_voltage),
    .beta       (in_ch.beta_voltage),
    .bus        (in_ch.bus_voltage),
    .pwm_period (pwm_period),
    .entry      (entry)
  );

  // Both active times divided side by side, one bit per stage.
  svpc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .entry  (entry),
    .result (quo)
  );

  // Clamp, build Ta/Tb/Tc and route to phases; drives the output register.
  svpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .quo        (quo),
    .pwm_period (pwm_period),
    .out_ch     (out_ch)
  );

endmodule

@@ hw/rtl/svpc_cfg.sv @@
module svpc_cfg import svpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [PER_W-1:0]      pwm_period
);

  logic [PER_W-1:0] pwm_period_r;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = paddr[CFG_ADDR_W-1] == REG_PWM_PERIOD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      pwm_period_r <= pwdata[PER_W-1:0];
    end
  end

  assign prdata     = hit ? CFG_DATA_W'(pwm_period_r) : '0;
  assign pwm_period = pwm_period_r;

endmodule

@@ hw/rtl/svpc_front.sv @@
module svpc_front import svpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic signed [VOLT_W-1:0] alpha,
  input  logic signed [VOLT_W-1:0] beta,
  input  logic        [VOLT_W-1:0] bus,
  input  logic        [PER_W-1:0]  pwm_period,
  output div_stage_t               entry
);

  logic signed [TERM_W-1:0] a_ext, b_ext;

  // stage 1: constant products
  logic                     v1_r;
  logic signed [TERM_W-1:0] s3a_r, ha_r, hb_r, u3_r, bq_r;
  logic        [VOLT_W-1:0] u1v_r;
  logic                     f1_r;

  // stage 2: sector and voltage terms
  logic                     v2_r;
  logic signed [TERM_W-1:0] t1_r, t2_r, t3_r;
  sector_t                  sec2_r;
  logic        [VOLT_W-1:0] u2v_r;
  logic                     f2_r;
  logic signed [TERM_W-1:0] t1_nxt, t2_nxt, s_m;
  logic                     c1, c2, c4;

  // stage 3: active-vector magnitudes
  logic                     v3_r;
  logic        [MAG_W-1:0]  ux_r, uy_r;
  logic        [SUM_W-1:0]  su3_r;
  sector_t                  sec3_r;
  logic        [VOLT_W-1:0] u3v_r;
  logic                     f3_r;
  logic signed [TERM_W-1:0] sx, sy;
  logic        [MAG_W-1:0]  ux_nxt, uy_nxt;

  // stage 4: scale by period, overmodulation test
  logic                     v4_r;
  logic        [PROD_W-1:0] xp_r, yp_r;
  logic        [SUM_W-1:0]  su4_r;
  logic        [VOLT_W-1:0] u4v_r;
  tag_t                     tag4_r;
  logic                     ovm_nxt;

  assign a_ext = TERM_W'(alpha);
  assign b_ext = TERM_W'(beta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3a_r <= a_ext * K_SQRT3;
      ha_r  <= a_ext * K_THREE_HALVES;
      hb_r  <= b_ext * K_HALF_SQRT3;
      u3_r  <= b_ext * K_SQRT3;
      bq_r  <= b_ext <<< FRAC_W;
      u1v_r <= bus;
      f1_r  <= bus == '0;
    end
  end

  assign t1_nxt = hb_r - ha_r;
  assign t2_nxt = hb_r + ha_r;
  assign s_m    = -s3a_r;
  assign c1     = bq_r > 0;
  assign c2     = (s3a_r - bq_r) > 0;
  assign c4     = (s_m - bq_r) > 0;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r   <= t1_nxt;
      t2_r   <= t2_nxt;
      t3_r   <= u3_r;
      sec2_r <= sector_t'({c4, c2, c1});
      u2v_r  <= u1v_r;
      f2_r   <= f1_r;
    end
  end

  always_comb begin
    unique case (sec2_r)
      SEC_1:   begin sx = t1_r;  sy = t2_r;  end
      SEC_2:   begin sx = t2_r;  sy = -t3_r; end
      SEC_3:   begin sx = -t1_r; sy = t3_r;  end
      SEC_4:   begin sx = -t3_r; sy = t1_r;  end
      SEC_5:   begin sx = t3_r;  sy = -t2_r; end
      SEC_6:   begin sx = -t2_r; sy = -t1_r; end
      default: begin sx = '0;    sy = '0;    end
    endcase
  end

  assign ux_nxt = (sx > 0) ? sx[MAG_W-1:0] : '0;
  assign uy_nxt = (sy > 0) ? sy[MAG_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      su3_r  <= SUM_W'(ux_nxt) + SUM_W'(uy_nxt);
      sec3_r <= sec2_r;
      u3v_r  <= u2v_r;
      f3_r   <= f2_r;
    end
  end

  assign ovm_nxt = (pwm_period != '0) && (su3_r > SUM_W'({u3v_r, {FRAC_W{1'b0}}}));

  always_ff @(posedge clk) begin
    if (adv) begin
      xp_r         <= PROD_W'(ux_r) * PROD_W'(pwm_period);
      yp_r         <= PROD_W'(uy_r) * PROD_W'(pwm_period);
      su4_r        <= su3_r;
      u4v_r        <= u3v_r;
      tag4_r.sector <= sec3_r;
      tag4_r.ovm    <= ovm_nxt;
      tag4_r.fault  <= f3_r;
    end
  end

  // Overmodulated: numerator is x*P*2^16 over the magnitude sum, else x*P over bus.
  always_comb begin
    entry.vld = v4_r;
    entry.tag = tag4_r;
    entry.x.quo = '0;
    entry.y.quo = '0;
    if (tag4_r.ovm) begin
      entry.x.rem = REM_W'(xp_r >> (QUO_W - FRAC_W));
      entry.y.rem = REM_W'(yp_r >> (QUO_W - FRAC_W));
      entry.x.num = QUO_W'(xp_r << FRAC_W);
      entry.y.num = QUO_W'(yp_r << FRAC_W);
      entry.dvs   = su4_r;
    end else begin
      entry.x.rem = REM_W'(xp_r >> QUO_W);
      entry.y.rem = REM_W'(yp_r >> QUO_W);
      entry.x.num = xp_r[QUO_W-1:0];
      entry.y.num = yp_r[QUO_W-1:0];
      entry.dvs   = SUM_W'(u4v_r);
    end
  end

endmodule

@@ hw/rtl/svpc_div.sv @@
module svpc_div import svpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  div_stage_t entry,
  output div_stage_t result
);

  div_stage_t stage_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage_r[k].vld <= 1'b0;
      end
    end else if (adv) begin
      stage_r[0] <= stage_step(entry);
      for (int k = 1; k < DIV_STAGES; k++) begin
        stage_r[k] <= stage_step(stage_r[k-1]);
      end
    end
  end

  assign result = stage_r[DIV_STAGES-1];

endmodule

@@ hw/rtl/svpc_back.sv @@
module svpc_back import svpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  div_stage_t        quo,
  input  logic [PER_W-1:0]  pwm_period,
  svpc_out_if.source        out_ch
);

  logic [FULL_W-1:0] full;

  logic              v1_r, v2_r, v3_r;
  logic [FULL_W-1:0] tx1_r, ty1_r;
  tag_t              tag1_r, tag2_r;
  logic [FULL_W-1:0] tx_c, room, ty_c;

  logic [FULL_W-1:0] t0_r, hx_r, hy_r;

  logic [FULL_W-1:0] ta, tb, tc;
  logic [CMP_W-1:0]  ca, cb, cc;
  logic [CMP_W-1:0]  cmp_a_nxt, cmp_b_nxt, cmp_c_nxt;
  logic              zero;
  logic [CMP_W-1:0]  cmp_a_r, cmp_b_r, cmp_c_r;
  logic              ovm_r, fault_r;

  assign full = {pwm_period, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= quo.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // clamp the active times into the period
  assign tx_c = (quo.x.quo > full) ? full : quo.x.quo;
  assign room = full - tx_c;
  assign ty_c = (quo.y.quo > room) ? room : quo.y.quo;

  always_ff @(posedge clk) begin
    if (adv) begin
      tx1_r  <= tx_c;
      ty1_r  <= ty_c;
      tag1_r <= quo.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r   <= full - tx1_r - ty1_r;
      hx_r   <= tx1_r >> 1;
      hy_r   <= ty1_r >> 1;
      tag2_r <= tag1_r;
    end
  end

  assign ta = t0_r >> 2;
  assign tb = ta + hx_r;
  assign tc = tb + hy_r;
  assign ca = ta[FRAC_W+CMP_W-1:FRAC_W];
  assign cb = tb[FRAC_W+CMP_W-1:FRAC_W];
  assign cc = tc[FRAC_W+CMP_W-1:FRAC_W];
  assign zero = tag2_r.fault || (tag2_r.sector == SEC_ZERO);

  always_comb begin
    unique case (tag2_r.sector)
      SEC_1:   begin cmp_a_nxt = cb; cmp_b_nxt = ca; cmp_c_nxt = cc; end
      SEC_2:   begin cmp_a_nxt = ca; cmp_b_nxt = cc; cmp_c_nxt = cb; end
      SEC_3:   begin cmp_a_nxt = ca; cmp_b_nxt = cb; cmp_c_nxt = cc; end
      SEC_4:   begin cmp_a_nxt = cc; cmp_b_nxt = cb; cmp_c_nxt = ca; end
      SEC_5:   begin cmp_a_nxt = cc; cmp_b_nxt = ca; cmp_c_nxt = cb; end
      SEC_6:   begin cmp_a_nxt = cb; cmp_b_nxt = cc; cmp_c_nxt = ca; end
      default: begin cmp_a_nxt = '0; cmp_b_nxt = '0; cmp_c_nxt = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmp_a_r <= zero ? '0 : cmp_a_nxt;
      cmp_b_r <= zero ? '0 : cmp_b_nxt;
      cmp_c_r <= zero ? '0 : cmp_c_nxt;
      ovm_r   <= tag2_r.ovm && !zero;
      fault_r <= tag2_r.fault;
    end
  end

  assign out_ch.valid         = v3_r;
  assign out_ch.compare_a     = cmp_a_r;
  assign out_ch.compare_b     = cmp_b_r;
  assign out_ch.compare_c     = cmp_c_r;
  assign out_ch.overmodulated = ovm_r;
  assign out_ch.bus_fault     = fault_r;

endmodule
